/* design/llfh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llfh_pkg
// Shared widths, constants and register codes for the light level filter.
// ----------------------------------------------------------------------------
package llfh_pkg;

    localparam int WINDOW_LEN  = 16;
    localparam int SLOT_W      = $clog2(WINDOW_LEN);
    localparam int SAMPLE_W    = 12;
    localparam int SUM_W       = SAMPLE_W + SLOT_W;
    localparam int PCT_W       = 7;
    localparam int PROD_W      = SAMPLE_W + PCT_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE  = 12'd4095;
    localparam logic [PCT_W-1:0]    PERCENT_MAX = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DARK_LIMIT   = 2'd0,
        CFG_LIGHT_LIMIT  = 2'd1,
        CFG_INVERSE_MODE = 2'd2
    } cfg_sel_t;

endpackage

/* design/llfh_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llfh_ring
// Sample ring memory: reads the oldest word of the window and overwrites it
// with the new sample in the same cycle. Per-slot valid bits stand in for
// the all-zero reset contents.
// ----------------------------------------------------------------------------
module llfh_ring
    import llfh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [SAMPLE_W-1:0] wr_data,
    output logic [SAMPLE_W-1:0] old_sample
);

    logic [SAMPLE_W-1:0]   ring_mem [WINDOW_LEN];
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic                  rd_valid_reg;
    logic                  rd_valid_next;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    logic [WINDOW_LEN-1:0] valid_reg;
    logic [WINDOW_LEN-1:0] valid_next;

    // read-first: the registered read returns the word being replaced
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rd_data_reg        <= ring_mem[slot_reg];
            ring_mem[slot_reg] <= wr_data;
        end
    end

    always_comb
    begin
        slot_next     = slot_reg;
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (wr_en)
        begin
            rd_valid_next       = valid_reg[slot_reg];
            valid_next[slot_reg] = 1'b1;
            if (slot_reg == SLOT_W'(WINDOW_LEN - 1))
                slot_next = '0;
            else
                slot_next = slot_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg     <= slot_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign old_sample = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* design/light_level_filter_hysteresis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_level_filter_hysteresis
// 16-sample moving average of converter readings, dark flag with
// hysteresis and an intensity percentage per sample.
// ----------------------------------------------------------------------------
// Stages A, B and the output register hold an accepted sample in turn.
// Throughput: one sample per cycle unless out_stall holds it back; the ring
// memory reads and replaces one slot and the running sum updates per cycle.
// Reset: ring reads as all zero (valid bits cleared), slot, sum and flag
// cleared, dark_limit 0, light_limit 4095, inverse_mode 0.
// ----------------------------------------------------------------------------
module light_level_filter_hysteresis
    import llfh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  sample,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SAMPLE_W-1:0]  average,
    output logic                 dark_flag,
    output logic [PCT_W-1:0]     intensity_percent
);

    logic [SAMPLE_W-1:0] dark_limit_reg;
    logic [SAMPLE_W-1:0] light_limit_reg;
    logic                inverse_mode_reg;

    logic                accept;
    logic                s1_adv;
    logic                s2_adv;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [SAMPLE_W-1:0] old_sample;

    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                dark_reg;
    logic                dark_next;
    logic [SAMPLE_W-1:0] avg_now;

    logic                s2_valid_reg;
    logic                s2_valid_next;
    logic [SAMPLE_W-1:0] s2_avg_reg;
    logic                s2_dark_reg;

    logic [PROD_W-1:0]   pct_prod;
    logic [PCT_W-1:0]    pct_q0;
    logic [SAMPLE_W:0]   pct_rem;
    logic [PCT_W-1:0]    pct_q;
    logic [PCT_W-1:0]    pct_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] out_avg_reg;
    logic                out_dark_reg;
    logic [PCT_W-1:0]    out_pct_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_limit_reg   <= '0;
            light_limit_reg  <= FULL_SCALE;
            inverse_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DARK_LIMIT:   dark_limit_reg   <= cfg_data;
                CFG_LIGHT_LIMIT:  light_limit_reg  <= cfg_data;
                CFG_INVERSE_MODE: inverse_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    assign s2_adv   = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign s2_valid_next  = s1_adv || (s2_valid_reg && !s2_adv);
    assign out_valid_next = s2_adv || (out_valid_reg && out_stall);

    // ---------------- stage A: ring access ----------------
    llfh_ring u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (accept),
        .wr_data    (sample),
        .old_sample (old_sample)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_sample_reg <= sample;
    end

    // ---------------- stage B: running sum and hysteresis ----------------
    always_comb
    begin
        sum_next  = sum_reg - SUM_W'(old_sample) + SUM_W'(s1_sample_reg);
        avg_now   = sum_next[SUM_W-1:SLOT_W];
        dark_next = dark_reg;
        if (inverse_mode_reg)
        begin
            if (avg_now > dark_limit_reg)
                dark_next = 1'b1;
            else if (avg_now < light_limit_reg)
                dark_next = 1'b0;
        end
        else
        begin
            if (avg_now < dark_limit_reg)
                dark_next = 1'b1;
            else if (avg_now > light_limit_reg)
                dark_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            dark_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            sum_reg  <= sum_next;
            dark_reg <= dark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_avg_reg  <= avg_now;
            s2_dark_reg <= dark_next;
        end
    end

    // ---------------- stage C: percentage ----------------
    // divide by 4095 = 4096 - 1: q0 = p >> 12, remainder = low bits + q0,
    // which stays below twice the divisor, so one correction step
    always_comb
    begin
        pct_prod = PROD_W'(s2_avg_reg) * PROD_W'(PERCENT_MAX);
        pct_q0   = pct_prod[PROD_W-1:SAMPLE_W];
        pct_rem  = {1'b0, pct_prod[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(pct_q0);
        if (pct_rem >= {1'b0, FULL_SCALE})
            pct_q = pct_q0 + PCT_W'(1);
        else
            pct_q = pct_q0;
        pct_next = inverse_mode_reg ? (PERCENT_MAX - pct_q) : pct_q;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_avg_reg  <= s2_avg_reg;
            out_dark_reg <= s2_dark_reg;
            out_pct_reg  <= pct_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign average           = out_avg_reg;
    assign dark_flag         = out_dark_reg;
    assign intensity_percent = out_pct_reg;

    // ---------------- assertions ----------------
    a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word lost before stage B");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_W'(WINDOW_LEN * 4095))
        else $error("running sum out of range");

    a_pct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pct_reg <= PERCENT_MAX))
        else $error("intensity percentage above 100");

    a_s2_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("stage C word not moved to output");

endmodule
